// ----- sv/projector_source_select_fsm_unit_assert.svh -----
// assertion helpers for the block's top module
`ifndef PROJECTOR_SOURCE_SELECT_FSM_UNIT_ASSERT_SVH
`define PROJECTOR_SOURCE_SELECT_FSM_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pssf check failed");

// next-cycle implication, checked outside reset
`define PSSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pssf check failed");

`endif

// ----- sv/pssf_pkg.sv -----
package pssf_pkg;

    // widths
    localparam int TIMER_BITS = 24;
    localparam int CFG_W      = 24;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int NUM_SRC    = 5;
    localparam int SRC_IDX_W  = 3;

    // register indexes
    localparam logic [1:0] REG_IGNITION = 2'd0;
    localparam logic [1:0] REG_SELECT   = 2'd1;
    localparam logic [1:0] REG_LOCKOUT  = 2'd2;
    localparam logic [1:0] REG_COOLDOWN = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] IGNITION_RST = CFG_W'(30000);
    localparam logic [CFG_W-1:0] SELECT_RST   = CFG_W'(2000);
    localparam logic [CFG_W-1:0] LOCKOUT_RST  = CFG_W'(2000);
    localparam logic [CFG_W-1:0] COOLDOWN_RST = CFG_W'(60000);

    // controller states; preview and selected run in source order
    // console one, console two, streaming, external, computer
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_INITIAL    = 4'd1,
        ST_IGNITION   = 4'd2,
        ST_PREDEFAULT = 4'd3,
        ST_PREV_C1    = 4'd4,
        ST_PREV_C2    = 4'd5,
        ST_PREV_STRM  = 4'd6,
        ST_PREV_EXT   = 4'd7,
        ST_PREV_PC    = 4'd8,
        ST_SEL_C1     = 4'd9,
        ST_SEL_C2     = 4'd10,
        ST_SEL_STRM   = 4'd11,
        ST_SEL_EXT    = 4'd12,
        ST_SEL_PC     = 4'd13,
        ST_COOLDOWN   = 4'd14
    } t_state;

    // source indexes
    localparam logic [SRC_IDX_W-1:0] SRC_C1   = 3'd0;
    localparam logic [SRC_IDX_W-1:0] SRC_C2   = 3'd1;
    localparam logic [SRC_IDX_W-1:0] SRC_STRM = 3'd2;
    localparam logic [SRC_IDX_W-1:0] SRC_EXT  = 3'd3;
    localparam logic [SRC_IDX_W-1:0] SRC_PC   = 3'd4;

    // led modes
    localparam logic [2:0] LED_KEEP = 3'd0;
    localparam logic [2:0] LED_OFF  = 3'd1;
    localparam logic [2:0] LED_ON   = 3'd2;
    localparam logic [2:0] LED_SLOW = 3'd3;
    localparam logic [2:0] LED_FAST = 3'd4;

    // projector commands
    localparam logic [2:0] PRJ_NONE   = 3'd0;
    localparam logic [2:0] PRJ_ON     = 3'd1;
    localparam logic [2:0] PRJ_OFF    = 3'd2;
    localparam logic [2:0] PRJ_SWITCH = 3'd3;
    localparam logic [2:0] PRJ_STREAM = 3'd4;

    // switch commands
    localparam logic [2:0] SW_NONE    = 3'd0;
    localparam logic [2:0] SW_DEFAULT = 3'd1;
    localparam logic [2:0] SW_PC      = 3'd2;
    localparam logic [2:0] SW_C1      = 3'd3;
    localparam logic [2:0] SW_C2      = 3'd4;
    localparam logic [2:0] SW_EXT     = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] ignition;
        logic [CFG_W-1:0] select_timeout;
        logic [CFG_W-1:0] lockout;
        logic [CFG_W-1:0] cooldown;
    } t_cfg;

    typedef struct packed {
        logic [2:0] led_computer;
        logic [2:0] led_console_two;
        logic [2:0] led_console_one;
        logic [2:0] led_external;
        logic [2:0] led_streaming;
        logic [2:0] led_status;
        logic [2:0] led_power;
        logic [2:0] led_source;
        logic [2:0] switch_cmd;
        logic [2:0] projector_cmd;
        logic [3:0] mode_code;
    } t_result;

    localparam int RES_W   = $bits(t_result);
    localparam int ODATA_W = ((RES_W + 7) / 8) * 8;

    // projector command that confirms a source
    function automatic logic [2:0] src_proj_cmd(input logic [SRC_IDX_W-1:0] k);
        logic [2:0] c;
        c = (k == SRC_STRM) ? PRJ_STREAM : PRJ_SWITCH;
        return c;
    endfunction

    // switch command that confirms a source
    function automatic logic [2:0] src_switch_cmd(input logic [SRC_IDX_W-1:0] k);
        logic [2:0] c;
        unique case (k)
            SRC_C1:   c = SW_C1;
            SRC_C2:   c = SW_C2;
            SRC_EXT:  c = SW_EXT;
            SRC_PC:   c = SW_PC;
            default:  c = SW_NONE;
        endcase
        return c;
    endfunction

    // following source in preview order
    function automatic logic [SRC_IDX_W-1:0] src_next(input logic [SRC_IDX_W-1:0] k);
        return (k == SRC_PC) ? SRC_C1 : SRC_IDX_W'(k + 1'b1);
    endfunction

    // preceding source in preview order
    function automatic logic [SRC_IDX_W-1:0] src_prev(input logic [SRC_IDX_W-1:0] k);
        return (k == SRC_C1) ? SRC_PC : SRC_IDX_W'(k - 1'b1);
    endfunction

endpackage

// ----- sv/pssf_cfg.sv -----
module pssf_cfg
    import pssf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // timer period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignition       <= IGNITION_RST;
            r_cfg.select_timeout <= SELECT_RST;
            r_cfg.lockout        <= LOCKOUT_RST;
            r_cfg.cooldown       <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_IGNITION: r_cfg.ignition       <= i_cfg_wdata;
                REG_SELECT:   r_cfg.select_timeout <= i_cfg_wdata;
                REG_LOCKOUT:  r_cfg.lockout        <= i_cfg_wdata;
                REG_COOLDOWN: r_cfg.cooldown       <= i_cfg_wdata;
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/pssf_step.sv -----
module pssf_step
    import pssf_pkg::*;
(
    input  t_state                i_state,
    input  logic [TIMER_BITS-1:0] i_elapsed,
    input  t_cfg                  i_cfg,
    input  logic                  i_power,
    input  logic                  i_source,
    output t_state                o_state,
    output logic [TIMER_BITS-1:0] o_elapsed,
    output logic                  o_timer_clr,
    output t_result               o_result
);

    logic [TIMER_BITS-1:0] inc;
    logic [CMP_W-1:0]      inc_x;
    logic                  exp_ign;
    logic                  exp_sel;
    logic                  exp_lock;
    logic                  exp_cool;
    logic [SRC_IDX_W-1:0]  k_prev;
    logic [SRC_IDX_W-1:0]  k_sel;
    logic [2:0]            src_led [NUM_SRC];
    t_state                n_state;
    logic                  clr;

    // saturating tick count and period compares
    assign inc      = (&i_elapsed) ? i_elapsed : TIMER_BITS'(i_elapsed + 1'b1);
    assign inc_x    = CMP_W'(inc);
    assign exp_ign  = inc_x >= CMP_W'(i_cfg.ignition);
    assign exp_sel  = inc_x >= CMP_W'(i_cfg.select_timeout);
    assign exp_lock = inc_x >= CMP_W'(i_cfg.lockout);
    assign exp_cool = inc_x >= CMP_W'(i_cfg.cooldown);

    // source index of preview and selected states
    assign k_prev = SRC_IDX_W'(4'(i_state) - 4'(ST_PREV_C1));
    assign k_sel  = SRC_IDX_W'(4'(i_state) - 4'(ST_SEL_C1));

    // state decode: led actions first, then transitions
    always_comb begin
        o_result = '0;
        n_state  = i_state;
        clr      = 1'b0;
        for (int i = 0; i < NUM_SRC; i++) begin
            src_led[i] = LED_KEEP;
        end
        unique case (i_state)
            ST_IDLE: begin
                o_result.led_source = LED_OFF;
                o_result.led_power  = LED_OFF;
                o_result.led_status = LED_OFF;
                for (int i = 0; i < NUM_SRC; i++) begin
                    src_led[i] = LED_OFF;
                end
                o_result.switch_cmd    = SW_DEFAULT;
                o_result.projector_cmd = PRJ_OFF;
                n_state = ST_INITIAL;
            end
            ST_INITIAL: begin
                o_result.led_status = LED_ON;
                o_result.led_power  = LED_ON;
                if (i_power) begin
                    o_result.led_power     = LED_OFF;
                    o_result.projector_cmd = PRJ_ON;
                    n_state = ST_IGNITION;
                end
            end
            ST_IGNITION: begin
                o_result.led_power = LED_SLOW;
                if (exp_ign) begin
                    clr     = 1'b1;
                    n_state = ST_PREDEFAULT;
                end
            end
            ST_PREDEFAULT: begin
                o_result.led_power     = LED_ON;
                o_result.led_status    = LED_OFF;
                o_result.projector_cmd = PRJ_SWITCH;
                o_result.switch_cmd    = SW_PC;
                n_state = ST_SEL_PC;
            end
            ST_PREV_C1, ST_PREV_C2, ST_PREV_STRM, ST_PREV_EXT, ST_PREV_PC: begin
                o_result.led_source       = LED_ON;
                src_led[src_prev(k_prev)] = LED_OFF;
                src_led[k_prev]           = LED_FAST;
                if (exp_sel) begin
                    o_result.projector_cmd = src_proj_cmd(k_prev);
                    o_result.switch_cmd    = src_switch_cmd(k_prev);
                    clr     = 1'b1;
                    n_state = t_state'(4'(ST_SEL_C1) + 4'(k_prev));
                end else if (i_source) begin
                    clr     = 1'b1;
                    n_state = t_state'(4'(ST_PREV_C1) + 4'(src_next(k_prev)));
                end
            end
            ST_SEL_C1, ST_SEL_C2, ST_SEL_STRM, ST_SEL_EXT, ST_SEL_PC: begin
                o_result.led_source = LED_OFF;
                src_led[k_sel]      = LED_ON;
                if (exp_lock) begin
                    // lockout over: source led comes back on
                    o_result.led_source = LED_ON;
                    if (i_source) begin
                        clr     = 1'b1;
                        n_state = t_state'(4'(ST_PREV_C1) + 4'(src_next(k_sel)));
                    end else if (i_power) begin
                        o_result.projector_cmd = PRJ_OFF;
                        clr     = 1'b1;
                        n_state = ST_COOLDOWN;
                    end
                end
            end
            ST_COOLDOWN: begin
                o_result.led_power  = LED_OFF;
                o_result.led_source = LED_OFF;
                o_result.led_status = LED_SLOW;
                for (int i = 0; i < NUM_SRC; i++) begin
                    src_led[i] = LED_OFF;
                end
                if (exp_cool) begin
                    clr     = 1'b1;
                    n_state = ST_INITIAL;
                end
            end
            default: begin
                n_state = i_state;
            end
        endcase
        o_result.led_console_one = src_led[SRC_C1];
        o_result.led_console_two = src_led[SRC_C2];
        o_result.led_streaming   = src_led[SRC_STRM];
        o_result.led_external    = src_led[SRC_EXT];
        o_result.led_computer    = src_led[SRC_PC];
        o_result.mode_code       = 4'(n_state);
    end

    assign o_state     = n_state;
    assign o_timer_clr = clr;
    assign o_elapsed   = clr ? '0 : inc;

endmodule

// ----- sv/projector_source_select_fsm_unit.sv -----
// an accepted input beat is registered, decoded, and its result beat registered for m_axis
// throughput: one beat per cycle while m_axis_tready holds; input register, one decode stage, result register
// m_axis_tready reaches s_axis_tready combinationally, no extra bubble on stall
// reset: i_rst_n synchronous active low; state idle, tick counter zero,
// timer periods to their defaults, both stages empty
`include "projector_source_select_fsm_unit_assert.svh"

module projector_source_select_fsm_unit
    import pssf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // [0] power_pressed, [1] source_pressed
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [3:0] mode_code, [6:4] projector_cmd, [9:7] switch_cmd, [12:10] led_source,
    // [15:13] led_power, [18:16] led_status, [21:19] led_streaming,
    // [24:22] led_external, [27:25] led_console_one, [30:28] led_console_two,
    // [33:31] led_computer, rest zero
    output logic [ODATA_W-1:0] m_axis_tdata
);

    t_cfg                  cfg;
    logic                  r_in_valid;
    logic                  r_in_power;
    logic                  r_in_source;
    logic                  r_out_valid;
    t_result               r_res;
    t_state                r_state;
    logic [TIMER_BITS-1:0] r_elapsed;
    t_state                n_state;
    logic [TIMER_BITS-1:0] n_elapsed;
    t_result               n_res;
    logic                  timer_clr;
    logic                  in_take;
    logic                  adv;

    pssf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pssf_step u_step (
        .i_state     (r_state),
        .i_elapsed   (r_elapsed),
        .i_cfg       (cfg),
        .i_power     (r_in_power),
        .i_source    (r_in_source),
        .o_state     (n_state),
        .o_elapsed   (n_elapsed),
        .o_timer_clr (timer_clr),
        .o_result    (n_res)
    );

    // handshake: decode stage advances when the result register frees up
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_IDLE;
            r_elapsed   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_elapsed   <= n_elapsed;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_power  <= s_axis_tdata[0];
            r_in_source <= s_axis_tdata[1];
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODATA_W'(r_res);

    // checks
    `PSSF_ASSERT_NEXT(a_timer_clear, adv && timer_clr, r_elapsed == '0)
    `PSSF_ASSERT_NEXT(a_state_hold, !adv, $stable(r_state) && $stable(r_elapsed))
    `PSSF_ASSERT_NEXT(a_mode_tracks_state, adv, r_res.mode_code == 4'(r_state))
    `PSSF_ASSERT_NOW(a_full_blocks_input, r_in_valid && r_out_valid && !m_axis_tready,
        !s_axis_tready)

endmodule

// ----- test/projector_source_select_fsm_unit_tb.sv -----
`timescale 1ns / 1ps

module projector_source_select_fsm_unit_tb;
    import pssf_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;

    typedef struct packed {
        logic source;
        logic power;
    } t_button_levels;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = REG_IGNITION;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;  // [0] power_pressed, [1] source_pressed
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [3:0] mode_code, [6:4] projector_cmd, [9:7] switch_cmd, [12:10] led_source,
    // [15:13] led_power, [18:16] led_status, [21:19] led_streaming,
    // [24:22] led_external, [27:25] led_console_one, [30:28] led_console_two,
    // [33:31] led_computer, rest zero
    logic [ODATA_W-1:0] m_axis_tdata;

    // controller copy: state, tick counter and timer periods
    t_state             ctl_state = ST_IDLE;
    logic [TIMER_BITS-1:0] tick_count = '0;
    logic [CFG_W-1:0]   cfg_ignition = IGNITION_RST;
    logic [CFG_W-1:0]   cfg_select = SELECT_RST;
    logic [CFG_W-1:0]   cfg_lockout = LOCKOUT_RST;
    logic [CFG_W-1:0]   cfg_cooldown = COOLDOWN_RST;

    t_button_levels     tick_q[$];
    t_result            result_q[$];
    bit                 stall_en = 1'b1;
    int unsigned        send_gap = 0;
    int unsigned        hold_gap = 0;
    int unsigned        mismatches = 0;
    int unsigned        ticks_sent = 0;
    int unsigned        results_seen = 0;
    int unsigned        settings_loaded = 0;
    int unsigned        cycles = 0;
    logic [15:0]        modes_seen = '0;

    projector_source_select_fsm_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic void all_leds(inout t_result r, input logic [2:0] mode);
        r.led_source      = mode;
        r.led_power       = mode;
        r.led_status      = mode;
        r.led_streaming   = mode;
        r.led_external    = mode;
        r.led_console_one = mode;
        r.led_console_two = mode;
        r.led_computer    = mode;
    endfunction

    function automatic void put_src_led(inout t_result r, input logic [SRC_IDX_W-1:0] k,
                                        input logic [2:0] mode);
        case (k)
            SRC_C1:   r.led_console_one = mode;
            SRC_C2:   r.led_console_two = mode;
            SRC_STRM: r.led_streaming   = mode;
            SRC_EXT:  r.led_external    = mode;
            default:  r.led_computer    = mode;
        endcase
    endfunction

    // one tick of the controller: counter, state leds, then transitions
    function automatic t_result advance_controller(input logic pwr, input logic src);
        t_result               r;
        logic [SRC_IDX_W-1:0]  k;
        logic [SRC_IDX_W-1:0]  nk;
        r = '0;
        if (tick_count != {TIMER_BITS{1'b1}})
            tick_count = tick_count + 1'b1;
        case (ctl_state)
            ST_IDLE: begin
                all_leds(r, LED_OFF);
                r.switch_cmd    = SW_DEFAULT;
                r.projector_cmd = PRJ_OFF;
                ctl_state       = ST_INITIAL;
            end
            ST_INITIAL: begin
                r.led_status = LED_ON;
                r.led_power  = LED_ON;
                if (pwr) begin
                    r.led_power     = LED_OFF;
                    r.projector_cmd = PRJ_ON;
                    ctl_state       = ST_IGNITION;
                end
            end
            ST_IGNITION: begin
                r.led_power = LED_SLOW;
                if (tick_count >= cfg_ignition) begin
                    tick_count = '0;
                    ctl_state  = ST_PREDEFAULT;
                end
            end
            ST_PREDEFAULT: begin
                r.led_power     = LED_ON;
                r.led_status    = LED_OFF;
                r.projector_cmd = PRJ_SWITCH;
                r.switch_cmd    = SW_PC;
                ctl_state       = ST_SEL_PC;
            end
            ST_PREV_C1, ST_PREV_C2, ST_PREV_STRM, ST_PREV_EXT, ST_PREV_PC: begin
                k  = SRC_IDX_W'(ctl_state - ST_PREV_C1);
                nk = (k == SRC_PC) ? SRC_C1 : SRC_IDX_W'(k + 1'b1);
                r.led_source = LED_ON;
                put_src_led(r, (k == SRC_C1) ? SRC_PC : SRC_IDX_W'(k - 1'b1), LED_OFF);
                put_src_led(r, k, LED_FAST);
                if (tick_count >= cfg_select) begin
                    // confirm the previewed source
                    r.projector_cmd = (k == SRC_STRM) ? PRJ_STREAM : PRJ_SWITCH;
                    case (k)
                        SRC_C1:  r.switch_cmd = SW_C1;
                        SRC_C2:  r.switch_cmd = SW_C2;
                        SRC_EXT: r.switch_cmd = SW_EXT;
                        SRC_PC:  r.switch_cmd = SW_PC;
                        default: r.switch_cmd = SW_NONE;
                    endcase
                    tick_count = '0;
                    ctl_state  = t_state'(ST_SEL_C1 + 4'(k));
                end else if (src) begin
                    tick_count = '0;
                    ctl_state  = t_state'(ST_PREV_C1 + 4'(nk));
                end
            end
            ST_SEL_C1, ST_SEL_C2, ST_SEL_STRM, ST_SEL_EXT, ST_SEL_PC: begin
                k  = SRC_IDX_W'(ctl_state - ST_SEL_C1);
                nk = (k == SRC_PC) ? SRC_C1 : SRC_IDX_W'(k + 1'b1);
                r.led_source = LED_OFF;
                put_src_led(r, k, LED_ON);
                // lockout over: source led on, buttons count again
                if (tick_count >= cfg_lockout) begin
                    r.led_source = LED_ON;
                    if (src) begin
                        tick_count = '0;
                        ctl_state  = t_state'(ST_PREV_C1 + 4'(nk));
                    end else if (pwr) begin
                        r.projector_cmd = PRJ_OFF;
                        tick_count      = '0;
                        ctl_state       = ST_COOLDOWN;
                    end
                end
            end
            ST_COOLDOWN: begin
                all_leds(r, LED_OFF);
                r.led_status = LED_SLOW;
                if (tick_count >= cfg_cooldown) begin
                    tick_count = '0;
                    ctl_state  = ST_INITIAL;
                end
            end
            default: ;
        endcase
        r.mode_code = ctl_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input side: present queued ticks, predict on each accepted beat
    always @(posedge i_clk) begin : drive_ticks
        t_button_levels nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                result_q.push_back(advance_controller(s_axis_tdata[0], s_axis_tdata[1]));
                ticks_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    nxt = tick_q.pop_front();
                    s_axis_tdata  <= {6'b0, nxt.source, nxt.power};
                    s_axis_tvalid <= 1'b1;
                    if (stall_en)
                        send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: random back-pressure, compare each beat with the oldest prediction
    always @(posedge i_clk) begin : watch_results
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[RES_W-1:0]);
                modes_seen[got.mode_code] = 1'b1;
                results_seen++;
                check_field("padding", 0, 32'(m_axis_tdata[ODATA_W-1:RES_W]));
                if (result_q.size() == 0) begin
                    $error("result beat with no tick pending, mode_code %0d", got.mode_code);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("mode_code", 32'(want.mode_code), 32'(got.mode_code));
                    check_field("projector_cmd", 32'(want.projector_cmd),
                                32'(got.projector_cmd));
                    check_field("switch_cmd", 32'(want.switch_cmd), 32'(got.switch_cmd));
                    check_field("led_source", 32'(want.led_source), 32'(got.led_source));
                    check_field("led_power", 32'(want.led_power), 32'(got.led_power));
                    check_field("led_status", 32'(want.led_status), 32'(got.led_status));
                    check_field("led_streaming", 32'(want.led_streaming),
                                32'(got.led_streaming));
                    check_field("led_external", 32'(want.led_external),
                                32'(got.led_external));
                    check_field("led_console_one", 32'(want.led_console_one),
                                32'(got.led_console_one));
                    check_field("led_console_two", 32'(want.led_console_two),
                                32'(got.led_console_two));
                    check_field("led_computer", 32'(want.led_computer),
                                32'(got.led_computer));
                end
            end
            if (hold_gap != 0) begin
                hold_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (stall_en)
                    hold_gap = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_tick(input logic pwr, input logic src);
        t_button_levels b;
        b.power  = pwr;
        b.source = src;
        tick_q.push_back(b);
    endtask

    // block is idle once every tick is in and every result is out
    task automatic wait_idle();
        while (tick_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timer(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_IGNITION: cfg_ignition = val;
            REG_SELECT:   cfg_select   = val;
            REG_LOCKOUT:  cfg_lockout  = val;
            default:      cfg_cooldown = val;
        endcase
    endtask

    task automatic load_timers(input logic [CFG_W-1:0] ign, input logic [CFG_W-1:0] sel,
                               input logic [CFG_W-1:0] lock, input logic [CFG_W-1:0] cool);
        write_timer(REG_IGNITION, ign);
        write_timer(REG_SELECT, sel);
        write_timer(REG_LOCKOUT, lock);
        write_timer(REG_COOLDOWN, cool);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // stimulus sequence
    initial begin : run_phases
        int unsigned phase;
        int unsigned n;
        int unsigned i;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default periods: power-up, ignition not yet over
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        wait_idle();

        // zero periods: every timer expires at once, both buttons together
        load_timers('0, '0, '0, '0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        wait_idle();

        // short periods: walk the whole preview ring, confirm, power press in lockout
        load_timers(24'd1, 24'd3, 24'd2, 24'd2);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        repeat (6) queue_tick(1'b0, 1'b1);
        repeat (3) queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        wait_idle();

        // random phases, each with its own timer settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_timers('1, '1, '1, '1);
                1: load_timers(24'd1, 24'd1, 24'd1, 24'd1);
                2: load_timers(24'($urandom_range(0, 8)), '1, '0, 24'($urandom_range(0, 8)));
                default: load_timers(24'($urandom_range(0, 30)), 24'($urandom_range(1, 12)),
                                     24'($urandom_range(0, 10)), 24'($urandom_range(0, 30)));
            endcase
            stall_en = (phase != 1) && ($urandom_range(0, 3) != 0);
            n = (phase == 0) ? 40 : 120;
            for (i = 0; i < n; i++) begin
                // mostly sparse presses so timers get to run out, some pure noise
                if ($urandom_range(0, 6) == 0)
                    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    queue_tick($urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0);
            end
            wait_idle();
        end

        $display("%0d ticks driven, %0d results checked under %0d timer settings",
                 ticks_sent, results_seen, settings_loaded);
        $display("%0d of 15 controller modes observed", $countones(modes_seen));
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- projector_source_select_fsm_unit.f -----
+incdir+sv
sv/pssf_pkg.sv
sv/pssf_cfg.sv
sv/pssf_step.sv
sv/projector_source_select_fsm_unit.sv
test/projector_source_select_fsm_unit_tb.sv
